### sv/pgpe_pkg.sv
`timescale 1ns / 1ps

package pgpe_pkg;

   // Line buffer size default
   localparam int LINE_BUFFER_WIDTH_DEFAULT = 512;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int PEN_W    = 11;
   localparam int XPOS_W   = 12;
   localparam int ROWS_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Register reset values
   localparam logic [1:0]  DEPTH_MODE_RST  = 2'd0;
   localparam logic [23:0] FORE_COLOR_RST  = 24'hFFFFFF;
   localparam logic [7:0]  FIRST_ROW_RST   = 8'd0;
   localparam logic [7:0]  LAST_ROW_RST    = 8'd255;
   localparam logic [8:0]  FONT_HEIGHT_RST = 9'd16;
   localparam logic [7:0]  WORD_SPACE_RST  = 8'd0;
   localparam logic [9:0]  RIGHT_LIMIT_RST = 10'd512;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_MODE  = 3'd0,
      CSR_FORE_COLOR  = 3'd1,
      CSR_FIRST_ROW   = 3'd2,
      CSR_LAST_ROW    = 3'd3,
      CSR_FONT_HEIGHT = 3'd4,
      CSR_WORD_SPACE  = 3'd5,
      CSR_RIGHT_LIMIT = 3'd6
   } csr_index_type;

   // Pixel depth codes
   typedef enum logic [1:0] {
      DEPTH_1BPP = 2'd0,
      DEPTH_2BPP = 2'd1,
      DEPTH_4BPP = 2'd2,
      DEPTH_8BPP = 2'd3
   } depth_type;

   typedef struct packed {
      logic [1:0]  depth_mode;
      logic [23:0] fore_color;
      logic [7:0]  first_row;
      logic [7:0]  last_row;
      logic [8:0]  font_height;
      logic [7:0]  word_space;
      logic [9:0]  right_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] glyph_byte;
      logic       new_glyph;
      logic [7:0] glyph_width;
   } item_type;

   typedef struct packed {
      logic [9:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [31:0] pixel_value;
      logic        pixel_write;
      logic        glyph_end;
      logic        line_full;
      logic        last_of_byte;
   } pixel_type;

   // Handshake between the holding stage and the expander
   typedef struct packed {
      logic step;
      logic release_item;
   } ctrl_type;

   // Level mask for the pixel depth
   function automatic logic [7:0] level_mask(input logic [1:0] depth);
      logic [7:0] m;
      begin
         unique case (depth_type'(depth))
            DEPTH_1BPP: m = 8'h01;
            DEPTH_2BPP: m = 8'h03;
            DEPTH_4BPP: m = 8'h0F;
            DEPTH_8BPP: m = 8'hFF;
            default:    m = 8'hFF;
         endcase
         return m;
      end
   endfunction

   // Scale a level to full 8-bit alpha
   function automatic logic [7:0] level_alpha(input logic [1:0] depth,
                                              input logic [7:0] level);
      logic [7:0] a;
      begin
         unique case (depth_type'(depth))
            DEPTH_1BPP: a = level[0] ? 8'hFF : 8'h00;
            DEPTH_2BPP: a = 8'(level[1:0] * 8'd85);
            DEPTH_4BPP: a = 8'(level[3:0] * 8'd17);
            DEPTH_8BPP: a = level;
            default:    a = level;
         endcase
         return a;
      end
   endfunction

endpackage

### sv/pgpe_csr.sv
`timescale 1ns / 1ps

module pgpe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [pgpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pgpe_pkg::CSR_DATA_W-1:0]  csr_data,
   output pgpe_pkg::cfg_type                cfg
);

   pgpe_pkg::cfg_type cfg_ff, cfg_in;

   // Decode a register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pgpe_pkg::csr_index_type'(csr_index))
            pgpe_pkg::CSR_DEPTH_MODE:  cfg_in.depth_mode  = csr_data[1:0];
            pgpe_pkg::CSR_FORE_COLOR:  cfg_in.fore_color  = csr_data[23:0];
            pgpe_pkg::CSR_FIRST_ROW:   cfg_in.first_row   = csr_data[7:0];
            pgpe_pkg::CSR_LAST_ROW:    cfg_in.last_row    = csr_data[7:0];
            pgpe_pkg::CSR_FONT_HEIGHT: cfg_in.font_height = csr_data[8:0];
            pgpe_pkg::CSR_WORD_SPACE:  cfg_in.word_space  = csr_data[7:0];
            pgpe_pkg::CSR_RIGHT_LIMIT: cfg_in.right_limit = csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode  <= pgpe_pkg::DEPTH_MODE_RST;
         cfg_ff.fore_color  <= pgpe_pkg::FORE_COLOR_RST;
         cfg_ff.first_row   <= pgpe_pkg::FIRST_ROW_RST;
         cfg_ff.last_row    <= pgpe_pkg::LAST_ROW_RST;
         cfg_ff.font_height <= pgpe_pkg::FONT_HEIGHT_RST;
         cfg_ff.word_space  <= pgpe_pkg::WORD_SPACE_RST;
         cfg_ff.right_limit <= pgpe_pkg::RIGHT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/pgpe_in_stage.sv
`timescale 1ns / 1ps

module pgpe_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pgpe_pkg::item_type  req_item,
   input  pgpe_pkg::ctrl_type  ctrl,
   output logic                held_valid,
   output pgpe_pkg::item_type  held_item
);

   logic               valid_ff, valid_in;
   pgpe_pkg::item_type item_ff, item_in;

   // Take a new request once the held byte is done
   assign req_ready = !valid_ff || ctrl.release_item;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_item;
      end else if (ctrl.step) begin
         // glyph start is handled on the first pixel only
         item_in.new_glyph = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

### sv/pgpe_expander.sv
`timescale 1ns / 1ps

module pgpe_expander #(
   parameter int LINE_BUFFER_WIDTH = pgpe_pkg::LINE_BUFFER_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  pgpe_pkg::cfg_type   cfg,
   input  logic                held_valid,
   input  pgpe_pkg::item_type  held_item,
   output pgpe_pkg::ctrl_type  ctrl,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pgpe_pkg::pixel_type rsp_pixel
);

   localparam logic [pgpe_pkg::XPOS_W-1:0] LBW = pgpe_pkg::XPOS_W'(LINE_BUFFER_WIDTH);

   // Glyph walk state
   logic [pgpe_pkg::PEN_W-1:0] pen_ff, pen_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] width_ff, width_in;
   logic [2:0] bit_ff, bit_in;
   logic       active_ff, active_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   pgpe_pkg::pixel_type pixel_ff, pixel_in;

   logic [3:0] bits;
   logic [8:0] fh1, lim, rows;
   logic       pen_full, start;
   logic [5:0] start_prod;
   logic [2:0] start_bit;
   logic [7:0] eff_col, eff_row, eff_width;
   logic [2:0] eff_bit;
   logic       emit, out_free, step;
   logic [4:0] shamt;
   logic [7:0] level, alpha;
   logic [3:0] bit_sum;
   logic       last_b, col_wrap, row_last, glyph_done, full_adv;
   logic [8:0] col_inc, row_inc;
   logic [pgpe_pkg::PEN_W-1:0] pen_adv;
   logic [pgpe_pkg::XPOS_W-1:0] xpos;

   // Row count and glyph start values
   always_comb begin
      bits = 4'd1 << cfg.depth_mode;
      fh1  = cfg.font_height - 9'd1;
      lim  = ({1'b0, cfg.last_row} < fh1) ? {1'b0, cfg.last_row} : fh1;
      if (cfg.font_height == 9'd0 || lim < {1'b0, cfg.first_row}) begin
         rows = 9'd0;
      end else begin
         rows = lim - {1'b0, cfg.first_row} + 9'd1;
      end
      pen_full   = pen_ff >= {1'b0, cfg.right_limit};
      start      = held_item.new_glyph;
      start_prod = 6'(held_item.glyph_width[2:0] * cfg.first_row[2:0]);
      start_bit  = 3'({3'b000, start_prod[2:0]} << cfg.depth_mode);
   end

   // Walk position for this cycle
   always_comb begin
      eff_col   = start ? 8'd0 : col_ff;
      eff_row   = start ? 8'd0 : row_ff;
      eff_bit   = start ? start_bit : bit_ff;
      eff_width = start ? held_item.glyph_width : width_ff;
      if (start) begin
         emit = !pen_full && held_item.glyph_width != 8'd0 && rows != 9'd0;
      end else begin
         emit = active_ff;
      end
      out_free = !rsp_valid_ff || rsp_ready;
      step     = held_valid && (!emit || out_free);
   end

   // Pixel level, position and end-of-glyph checks
   always_comb begin
      shamt = 5'd8 - {1'b0, bits} - {2'b00, eff_bit};
      if (shamt[4]) begin
         level = 8'd0;
      end else begin
         level = (held_item.glyph_byte >> shamt[3:0]) & pgpe_pkg::level_mask(cfg.depth_mode);
      end
      alpha      = pgpe_pkg::level_alpha(cfg.depth_mode, level);
      bit_sum    = {1'b0, eff_bit} + bits;
      last_b     = bit_sum[3];
      col_inc    = {1'b0, eff_col} + 9'd1;
      row_inc    = {1'b0, eff_row} + 9'd1;
      col_wrap   = col_inc >= {1'b0, eff_width};
      row_last   = row_inc >= rows;
      glyph_done = col_wrap && row_last;
      pen_adv    = pen_ff + pgpe_pkg::PEN_W'(eff_width) + pgpe_pkg::PEN_W'(cfg.word_space);
      full_adv   = pen_adv >= {1'b0, cfg.right_limit};
      xpos       = pgpe_pkg::XPOS_W'(pen_ff) + pgpe_pkg::XPOS_W'(eff_col);
   end

   // Release the held byte when it has nothing more to give
   always_comb begin
      ctrl.step         = step;
      ctrl.release_item = step && (!emit || last_b || glyph_done);
   end

   // Next walk state
   always_comb begin
      pen_in    = pen_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      width_in  = width_ff;
      bit_in    = bit_ff;
      active_in = active_ff;
      if (step) begin
         if (emit) begin
            width_in = eff_width;
            bit_in   = bit_sum[2:0];
            row_in   = eff_row;
            if (col_wrap) begin
               col_in = 8'd0;
               if (row_last) begin
                  pen_in    = pen_adv;
                  active_in = 1'b0;
               end else begin
                  row_in    = row_inc[7:0];
                  active_in = 1'b1;
               end
            end else begin
               col_in    = col_inc[7:0];
               active_in = 1'b1;
            end
         end else if (start && pen_full) begin
            active_in = 1'b0;
         end else if (start) begin
            // empty glyph: advance the pen at once
            width_in  = held_item.glyph_width;
            col_in    = 8'd0;
            row_in    = 8'd0;
            bit_in    = start_bit;
            pen_in    = pen_adv;
            active_in = 1'b0;
         end
      end
   end

   // Load the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pixel_in     = pixel_ff;
      if (step && emit) begin
         rsp_valid_in          = 1'b1;
         pixel_in.pixel_x      = xpos[9:0];
         pixel_in.pixel_y      = eff_row;
         pixel_in.pixel_value  = {alpha, cfg.fore_color};
         pixel_in.pixel_write  = (level != 8'd0) && (xpos < LBW);
         pixel_in.glyph_end    = glyph_done;
         pixel_in.line_full    = glyph_done && full_adv;
         pixel_in.last_of_byte = last_b || glyph_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         width_ff     <= '0;
         bit_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_ff       <= pen_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         bit_ff       <= bit_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = pixel_ff;

endmodule

### sv/packed_glyph_pixel_expander_unit.sv
`timescale 1ns / 1ps
// A byte request is taken into the holding register; its pixels then pass through the result register.
// Throughput: one pixel per cycle while the result channel is not stalled; a byte yields 1 to 8
// pixels, or none. The next byte is taken in the cycle of the last pixel.
// The pace is set by the single result register that holds one pixel at a time.
// Reset (synchronous) empties both registers, zeroes the pen and restores register defaults.

module packed_glyph_pixel_expander_unit #(
   parameter int LINE_BUFFER_WIDTH = pgpe_pkg::LINE_BUFFER_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // glyph_byte[7:0], glyph_width[15:8]
   input  logic                             req_tuser,  // new_glyph[0]
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [55:0]                      rsp_tdata,  // pixel_x[9:0], pixel_y[17:10],
                                                        // pixel_value[49:18], zero fill
   output logic [2:0]                       rsp_tuser,  // pixel_write[0], line_full[1],
                                                        // last_of_byte[2]
   output logic                             rsp_tlast,  // glyph_end
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pgpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pgpe_pkg::CSR_DATA_W-1:0]  csr_data
);

   pgpe_pkg::cfg_type   cfg;
   pgpe_pkg::item_type  req_item, held_item;
   pgpe_pkg::ctrl_type  ctrl;
   pgpe_pkg::pixel_type rsp_pixel;
   logic                held_valid;

   assign csr_ready = 1'b1;

   // Unpack the request
   always_comb begin
      req_item.glyph_byte  = req_tdata[7:0];
      req_item.glyph_width = req_tdata[15:8];
      req_item.new_glyph   = req_tuser;
   end

   pgpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pgpe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .ctrl       (ctrl),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   pgpe_expander #(
      .LINE_BUFFER_WIDTH (LINE_BUFFER_WIDTH)
   ) u_expander (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .held_valid (held_valid),
      .held_item  (held_item),
      .ctrl       (ctrl),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pixel  (rsp_pixel)
   );

   // Pack the result
   assign rsp_tdata = {6'b000000, rsp_pixel.pixel_value, rsp_pixel.pixel_y,
                       rsp_pixel.pixel_x};
   assign rsp_tuser = {rsp_pixel.last_of_byte, rsp_pixel.line_full, rsp_pixel.pixel_write};
   assign rsp_tlast = rsp_pixel.glyph_end;

   // A full line is only reported on a glyph's final pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("line_full outside glyph end");

   // The glyph's final pixel also closes its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2])
      else $error("glyph end without last_of_byte");

   // While a byte is held, a new request is taken only as that byte is released
   assert property (@(posedge clock) disable iff (reset)
      held_valid && req_tready |-> ctrl.release_item && ctrl.step)
      else $error("request taken over a held byte");

   // No result right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import pgpe_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int RANDOM_REQUESTS  = 396;
   localparam int PEN_BUDGET       = 950;
   localparam int RIGHT_LIMIT_MAX  = 1023;
   localparam int PHASE_LENGTH     = 40;
   localparam int IDLE_PERCENT     = 24;
   localparam int MAX_REPORTS      = 40;

   // Model of the expander: tracks pen and bit position, queues pixels per request
   class glyph_scoreboard;
      depth_type   bpp_code    = depth_type'(DEPTH_MODE_RST);
      logic [23:0] ink_color   = FORE_COLOR_RST;
      logic [7:0]  top_row     = FIRST_ROW_RST;
      logic [7:0]  bottom_row  = LAST_ROW_RST;
      logic [8:0]  cell_height = FONT_HEIGHT_RST;
      logic [7:0]  gap_after   = WORD_SPACE_RST;
      logic [9:0]  limit_x     = RIGHT_LIMIT_RST;

      logic [10:0] pen_x        = '0;
      logic [7:0]  col_in_glyph = '0;
      logic [7:0]  row_in_glyph = '0;
      logic [7:0]  width_now    = '0;
      logic [2:0]  bit_offset   = '0;
      bit          in_glyph     = 1'b0;
      bit          line_closed  = 1'b0;

      pixel_type expected_pixels[$];
      int errors        = 0;
      int checked       = 0;
      int requests_used = 0;
      int glyphs_done   = 0;
      int lines_full    = 0;
      int edge_pixels   = 0;

      function int pending();
         return expected_pixels.size();
      endfunction

      function void set_register(csr_index_type idx, logic [23:0] val);
         case (idx)
            CSR_DEPTH_MODE:  bpp_code    = depth_type'(val[1:0]);
            CSR_FORE_COLOR:  ink_color   = val;
            CSR_FIRST_ROW:   top_row     = val[7:0];
            CSR_LAST_ROW:    bottom_row  = val[7:0];
            CSR_FONT_HEIGHT: cell_height = val[8:0];
            CSR_WORD_SPACE:  gap_after   = val[7:0];
            CSR_RIGHT_LIMIT: limit_x     = val[9:0];
            default: ;
         endcase
      endfunction

      // Visible rows, taken from the live register values
      function int visible_rows();
         int lim;
         lim = int'(bottom_row);
         if (int'(cell_height) - 1 < lim) lim = int'(cell_height) - 1;
         if (lim < int'(top_row)) return 0;
         return lim - int'(top_row) + 1;
      endfunction

      function void step_pen();
         pen_x       = 11'(pen_x + width_now + gap_after);
         line_closed = (pen_x >= limit_x);
         in_glyph    = 1'b0;
      endfunction

      // Expand one accepted request into the pixels it should produce
      function void note_request(logic [7:0] data_byte, logic first, logic [7:0] width);
         int bits, lmask, rows, level, xpos, npos, ncol, n;
         bit lastb, fin;
         pixel_type px;
         bits  = 1 << int'(bpp_code);
         lmask = (1 << bits) - 1;
         rows  = visible_rows();
         if (first) begin
            in_glyph    = 1'b0;
            line_closed = (pen_x >= limit_x);
            if (line_closed) return;
            width_now    = width;
            col_in_glyph = '0;
            row_in_glyph = '0;
            bit_offset   = 3'((bits * int'(width) * int'(top_row)) & 7);
            if (width == 0 || rows == 0) begin
               requests_used++;
               step_pen();
               return;
            end
            in_glyph = 1'b1;
         end
         if (!in_glyph) return;
         requests_used++;
         n = 0;
         while (in_glyph && n < 8) begin
            level = (int'(data_byte) >> (8 - bits - int'(bit_offset))) & lmask;
            xpos  = int'(pen_x) + int'(col_in_glyph);
            px.pixel_x     = xpos[9:0];
            px.pixel_y     = row_in_glyph;
            px.pixel_value = {8'((level * 255) / lmask), ink_color};
            px.pixel_write = (level != 0) && (xpos < LINE_BUFFER_WIDTH_DEFAULT);
            if (xpos >= LINE_BUFFER_WIDTH_DEFAULT) edge_pixels++;
            npos       = int'(bit_offset) + bits;
            lastb      = (npos >= 8);
            bit_offset = 3'(npos);
            ncol       = int'(col_in_glyph) + 1;
            fin        = 1'b0;
            if (ncol >= int'(width_now)) begin
               col_in_glyph = '0;
               if (int'(row_in_glyph) + 1 >= rows) begin
                  fin = 1'b1;
                  step_pen();
               end else begin
                  row_in_glyph = row_in_glyph + 8'd1;
               end
            end else begin
               col_in_glyph = 8'(ncol);
            end
            px.glyph_end    = fin;
            px.line_full    = fin && line_closed;
            px.last_of_byte = lastb || fin;
            if (fin) begin
               glyphs_done++;
               if (line_closed) lines_full++;
            end
            expected_pixels.push_back(px);
            n++;
            if (lastb) break;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: pixel %0d %s expected %0h actual %0h",
                        $time, checked, name, want, seen);
         end
      endfunction

      // Compare one delivered pixel with the oldest one still owed
      function void check_pixel(pixel_type seen);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: pixel expected none actual x=%0d y=%0d value=%08h",
                        $time, seen.pixel_x, seen.pixel_y, seen.pixel_value);
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         compare_field("pixel_x",      32'(want.pixel_x),      32'(seen.pixel_x));
         compare_field("pixel_y",      32'(want.pixel_y),      32'(seen.pixel_y));
         compare_field("pixel_value",  want.pixel_value,       seen.pixel_value);
         compare_field("pixel_write",  32'(want.pixel_write),  32'(seen.pixel_write));
         compare_field("glyph_end",    32'(want.glyph_end),    32'(seen.glyph_end));
         compare_field("line_full",    32'(want.line_full),    32'(seen.line_full));
         compare_field("last_of_byte", 32'(want.last_of_byte), 32'(seen.last_of_byte));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // glyph_byte[7:0], glyph_width[15:8]
   logic                  req_tuser;   // new_glyph[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [55:0]           rsp_tdata;   // pixel_x[9:0], pixel_y[17:10], pixel_value[49:18]
   logic [2:0]            rsp_tuser;   // pixel_write[0], line_full[1], last_of_byte[2]
   logic                  rsp_tlast;   // glyph_end
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   glyph_scoreboard sb;
   bit        steady = 1'b0;
   int        sent_count = 0;
   int        cycles = 0;
   pixel_type seen_pixel;

   packed_glyph_pixel_expander_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Check accepted pixels, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_pixel.pixel_x      = rsp_tdata[9:0];
         seen_pixel.pixel_y      = rsp_tdata[17:10];
         seen_pixel.pixel_value  = rsp_tdata[49:18];
         seen_pixel.pixel_write  = rsp_tuser[0];
         seen_pixel.line_full    = rsp_tuser[1];
         seen_pixel.last_of_byte = rsp_tuser[2];
         seen_pixel.glyph_end    = rsp_tlast;
         sb.check_pixel(seen_pixel);
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Hold requests until every owed pixel has arrived
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one request, with a random gap ahead of it
   task automatic send_request(logic [7:0] data_byte, logic first, logic [7:0] width);
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PERCENT);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {width, data_byte};
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      sb.note_request(data_byte, first, width);
   endtask

   task automatic write_register(csr_index_type idx, logic [23:0] val);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_register(idx, val);
   endtask

   task automatic configure(depth_type d, logic [23:0] ink, int top, int bottom,
                            int height, int gap, int limit);
      write_register(CSR_DEPTH_MODE,  24'(d));
      write_register(CSR_FORE_COLOR,  ink);
      write_register(CSR_FIRST_ROW,   24'(top));
      write_register(CSR_LAST_ROW,    24'(bottom));
      write_register(CSR_FONT_HEIGHT, 24'(height));
      write_register(CSR_WORD_SPACE,  24'(gap));
      write_register(CSR_RIGHT_LIMIT, 24'(limit));
   endtask

   // Pick a random register setting, keeping glyphs short
   task automatic random_phase();
      depth_type   d;
      logic [23:0] ink;
      int top, bottom, height, gap, limit;
      d = depth_type'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
         0:       ink = 24'h000000;
         1:       ink = 24'hFFFFFF;
         default: ink = 24'($urandom);
      endcase
      top = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 6);
      if (top == 255) begin
         bottom = 255;
         height = 256;
      end else begin
         height = top + $urandom_range(1, 16);
         bottom = ($urandom_range(0, 4) == 0) ? 255 : top + $urandom_range(0, 12);
         // occasionally leave no visible rows
         if (top > 0 && $urandom_range(0, 9) == 0) bottom = top - 1;
         if (top > 0 && $urandom_range(0, 9) == 0) height = $urandom_range(1, top);
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : $urandom_range(0, 1);
      limit = RIGHT_LIMIT_MAX;
      if ($urandom_range(0, 4) == 0) begin
         limit = int'(sb.pen_x) + $urandom_range(0, 24);
         if (limit > RIGHT_LIMIT_MAX) limit = RIGHT_LIMIT_MAX;
      end
      configure(d, ink, top, bottom, height, gap, limit);
   endtask

   // Send a glyph start and its bytes; a few are cut short
   task automatic send_glyph();
      logic [7:0] width;
      int cut, sent;
      width = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 8))
                                           : 8'($urandom_range(1, 3));
      send_request(8'($urandom), 1'b1, width);
      cut  = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, 3)) : -1;
      sent = 0;
      while (sb.in_glyph && sent != cut) begin
         send_request(8'($urandom), 1'b0, 8'($urandom));
         sent++;
      end
   endtask

   initial begin
      int base, rel, phase_mark;
      bit paused_once;
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_DEPTH_MODE;
      csr_data    = '0;
      paused_once = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: stray byte, then a one-column glyph of 16 rows
      send_request(8'hA5, 1'b0, 8'h3C);
      send_request(8'hFF, 1'b1, 8'd1);
      send_request(8'h00, 1'b0, 8'hFF);

      // 8 bits per pixel, one row, black ink: full, zero and mid levels
      configure(DEPTH_8BPP, 24'h000000, 2, 2, 16, 0, int'(RIGHT_LIMIT_RST));
      send_request(8'hFF, 1'b1, 8'd3);
      send_request(8'h00, 1'b0, 8'd0);
      send_request(8'h80, 1'b0, 8'd0);

      // 2 bits per pixel with a nonzero start bit, then a restart mid-glyph
      configure(DEPTH_2BPP, 24'h123456, 3, 4, 16, 0, int'(RIGHT_LIMIT_RST));
      send_request(8'h1B, 1'b1, 8'd3);
      send_request(8'hE4, 1'b0, 8'd0);
      send_request(8'hAA, 1'b1, 8'd255);
      send_request(8'h55, 1'b1, 8'd1);
      send_request(8'hC0, 1'b0, 8'd0);

      // 4 bits per pixel, rows clamped by the cell height, widest word space
      configure(DEPTH_4BPP, 24'hFFFFFF, 1, 255, 3, 255, RIGHT_LIMIT_MAX);
      send_request(8'h0F, 1'b1, 8'd1);
      send_request(8'h70, 1'b0, 8'd0);
      send_request(8'h00, 1'b1, 8'd0);

      // Last row of the tallest cell
      configure(DEPTH_2BPP, 24'h000000, 255, 255, 256, 1, RIGHT_LIMIT_MAX);
      send_request(8'h03, 1'b1, 8'd1);

      // No visible rows, then a stray byte
      configure(DEPTH_1BPP, 24'h00FF00, 5, 4, 16, 1, RIGHT_LIMIT_MAX);
      send_request(8'hFF, 1'b1, 8'd3);
      send_request(8'h12, 1'b0, 8'd0);

      // Zero-width glyph in a one-row cell
      configure(DEPTH_1BPP, 24'hABCDEF, 0, 255, 1, 2, RIGHT_LIMIT_MAX);
      send_request(8'h00, 1'b1, 8'd0);

      // Shrink the row count while a glyph is open
      configure(DEPTH_1BPP, 24'h55AA55, 0, 7, 16, 0, RIGHT_LIMIT_MAX);
      send_request(8'hC3, 1'b1, 8'd2);
      write_register(CSR_LAST_ROW, 24'd1);
      send_request(8'h5A, 1'b0, 8'd0);

      // Fill the line, then try to draw past it
      write_register(CSR_RIGHT_LIMIT, 24'(sb.pen_x + 11'd2));
      send_request(8'hF0, 1'b1, 8'd2);
      send_request(8'hFF, 1'b1, 8'd1);
      send_request(8'hFF, 1'b0, 8'd0);
      write_register(CSR_RIGHT_LIMIT, 24'd0);
      send_request(8'h81, 1'b1, 8'd4);

      // Random glyph streams over changing settings
      random_phase();
      phase_mark = sent_count;
      base = sent_count;
      while (sent_count - base < RANDOM_REQUESTS && sb.pen_x < PEN_BUDGET) begin
         rel    = sent_count - base;
         steady = (rel >= 150 && rel < 230);
         if (sent_count - phase_mark >= PHASE_LENGTH && !sb.in_glyph) begin
            random_phase();
            phase_mark = sent_count;
         end
         if (!paused_once && rel >= 300 && !sb.in_glyph) begin
            hold_until_drained();
            paused_once = 1'b1;
         end
         if ($urandom_range(0, 99) < 5)
            send_request(8'($urandom), 1'b0, 8'($urandom));
         else
            send_glyph();
      end
      steady = 1'b0;

      hold_until_drained();
      repeat (16) @(posedge clock);
      $display("Sent %0d requests (%0d expanded), checked %0d pixels, %0d beyond the buffer",
               sent_count, sb.requests_used, sb.checked, sb.edge_pixels);
      $display("Finished %0d glyphs, %0d with the line full, pen ended at %0d",
               sb.glyphs_done, sb.lines_full, sb.pen_x);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d pixels never delivered", sb.errors, sb.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
